### src/spb_pkg.sv
package spb_pkg;

  localparam int NUM_BARS     = 64;
  localparam int NUM_CHANNELS = 125;

  localparam int BAR_W       = $clog2(NUM_BARS);
  localparam int CH_W        = 7;
  localparam int HT_W        = 6;
  localparam int ROW_W       = 64;
  localparam int CNT_W       = 7;
  localparam int FRM_W       = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 128;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [HT_W-1:0]  MAX_HEIGHT_RST = HT_W'(40);
  localparam logic [CH_W-1:0]  TOP_CH         = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_ENABLE = 1'b0,
    REG_MAX_HEIGHT  = 1'b1
  } cfg_reg_t;

  typedef logic [BAR_W-1:0] bar_t;
  typedef logic [HT_W-1:0]  ht_t;

  typedef struct packed {
    ht_t peak_h;
    ht_t bar_h;
  } bar_state_t;

  typedef bar_t bar_lut_t [2**CH_W];

  function automatic bar_lut_t build_bar_lut();
    bar_lut_t lut;
    for (int i = 0; i < 2**CH_W; i++) begin
      lut[i] = BAR_W'((i * (NUM_BARS - 1)) / (NUM_CHANNELS - 1));
    end
    return lut;
  endfunction

  localparam bar_lut_t BAR_LUT = build_bar_lut();

endpackage

### src/spb_ram.sv
module spb_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/spb_update.sv
module spb_update (
  input  logic                strong_sig,
  input  logic                carrier,
  input  spb_pkg::ht_t        max_height,
  input  spb_pkg::bar_state_t old_st,
  output spb_pkg::bar_state_t new_st,
  output logic                hit
);

  import spb_pkg::*;

  ht_t target;
  ht_t h;
  ht_t p;

  always_comb begin
    priority if (strong_sig) begin
      target = max_height;
    end else if (carrier) begin
      target = max_height >> 1;
    end else begin
      target = '0;
    end
  end

  assign hit = (target != '0);

  always_comb begin
    priority if (target > old_st.bar_h) begin
      h = target;
    end else if (old_st.bar_h != '0) begin
      h = old_st.bar_h - HT_W'(1);
    end else begin
      h = '0;
    end
  end

  always_comb begin
    priority if (h > old_st.peak_h) begin
      p = h;
    end else if (old_st.peak_h != '0) begin
      p = old_st.peak_h - HT_W'(1);
    end else begin
      p = '0;
    end
  end

  assign new_st.bar_h  = h;
  assign new_st.peak_h = p;

endmodule

### src/spectrum_bar_peak_hold_unit.sv
// An accepted beat is held in the input stage, and its result beat is registered into the
// output stage once that stage is empty or its beat is being taken.
// Throughput: one input beat per cycle, sustained while the output is not stalled, limited
// by the single read-modify-write of the bar memory, with a bypass for back-to-back beats on one bar.
// Reset (rst_n, synchronous, active low) empties the pipeline, restores the
// configuration defaults and makes every bar and peak read as zero at once.
module spectrum_bar_peak_hold_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [6:0] channel, [7] strong_signal, [8] carrier_seen, zero above.
  input  logic [spb_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [5:0] bar_index, [11:6] bar_height, [17:12] peak_height,
  // [81:18] waterfall_row, [88:82] signals_found, [120:89] frame_count,
  // zero above.
  output logic [spb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [spb_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [spb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import spb_pkg::*;

  logic                    scan_en_r;
  ht_t                     max_h_r;

  logic [CH_W-1:0]         in_ch;
  logic                    in_take;
  bar_t                    in_bar;

  logic                    a_valid_r;
  bar_t                    a_bar_r;
  logic                    a_strong_r;
  logic                    a_carrier_r;
  logic                    a_top_r;
  logic                    a_fire;
  logic                    fwd_r;
  bar_state_t              fwd_st_r;
  logic                    rd_vld_r;
  logic [NUM_BARS-1:0]     vld_r;
  logic [$bits(bar_state_t)-1:0] ram_rdata;
  bar_state_t              old_st;
  bar_state_t              new_st;
  logic                    hit;

  logic [NUM_BARS-1:0]     occ_r;
  logic [NUM_BARS-1:0]     occ_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic [FRM_W-1:0]        frames_r;
  logic [FRM_W-1:0]        frames_nxt;

  logic                    out_valid_r;
  logic                    out_last_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;
  logic [OUT_TDATA_W-1:0]  out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r <= 1'b0;
      max_h_r   <= MAX_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_SCAN_ENABLE: scan_en_r <= cfg_wdata[0];
        REG_MAX_HEIGHT:  max_h_r   <= cfg_wdata[HT_W-1:0];
      endcase
    end
  end

  assign in_ch     = in_tdata[CH_W-1:0];
  assign in_bar    = BAR_LUT[in_ch];
  assign a_fire    = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_fire;
  assign in_take   = in_tvalid && in_tready && scan_en_r && (in_ch <= TOP_CH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      if (in_tready) begin
        a_valid_r <= in_take;
      end
      if (in_take) begin
        fwd_r <= a_fire && (a_bar_r == in_bar);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_bar_r     <= in_bar;
      a_strong_r  <= in_tdata[CH_W];
      a_carrier_r <= in_tdata[CH_W+1];
      a_top_r     <= (in_ch == TOP_CH);
      fwd_st_r    <= new_st;
      rd_vld_r    <= vld_r[in_bar];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (a_fire) begin
      vld_r[a_bar_r] <= 1'b1;
    end
  end

  spb_ram #(
    .ADDR_W (BAR_W),
    .DATA_W ($bits(bar_state_t))
  ) u_ram (
    .clk   (clk),
    .we    (a_fire),
    .waddr (a_bar_r),
    .wdata (new_st),
    .re    (in_take),
    .raddr (in_bar),
    .rdata (ram_rdata)
  );

  always_comb begin
    priority if (fwd_r) begin
      old_st = fwd_st_r;
    end else if (rd_vld_r) begin
      old_st = bar_state_t'(ram_rdata);
    end else begin
      old_st = '0;
    end
  end

  spb_update u_update (
    .strong_sig (a_strong_r),
    .carrier    (a_carrier_r),
    .max_height (max_h_r),
    .old_st     (old_st),
    .new_st     (new_st),
    .hit        (hit)
  );

  always_comb begin
    occ_nxt          = occ_r;
    occ_nxt[a_bar_r] = (new_st.bar_h != '0);
  end

  assign cnt_nxt    = (hit && (cnt_r != CNT_MAX)) ? cnt_r + CNT_W'(1) : cnt_r;
  assign frames_nxt = frames_r + FRM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      cnt_r    <= '0;
      frames_r <= '0;
    end else if (a_fire) begin
      occ_r <= occ_nxt;
      if (a_top_r) begin
        cnt_r    <= '0;
        frames_r <= frames_nxt;
      end else begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[BAR_W-1:0]         = a_bar_r;
    out_data_nxt[BAR_W+HT_W-1:BAR_W] = new_st.bar_h;
    out_data_nxt[BAR_W+2*HT_W-1:BAR_W+HT_W] = new_st.peak_h;
    if (a_top_r) begin
      out_data_nxt[BAR_W+2*HT_W +: ROW_W] = ROW_W'(occ_nxt);
      out_data_nxt[BAR_W+2*HT_W+ROW_W +: CNT_W] = cnt_nxt;
      out_data_nxt[BAR_W+2*HT_W+ROW_W+CNT_W +: FRM_W] = frames_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      out_data_r <= out_data_nxt;
      out_last_r <= a_top_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### src/spb_checker.sv
module spb_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [spb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic                                out_tlast
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result beat shown right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled result beat changed.");

  a_row_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[120:18] == '0)
    else $error("Sweep fields set on a beat that does not end the sweep.");

  a_end_on_top_bar: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[5:0] == 6'd63)
    else $error("Sweep ended on a bar other than the top one.");

  a_peak_above_bar: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:12] >= out_tdata[11:6])
    else $error("Peak height below bar height.");

endmodule

bind spectrum_bar_peak_hold_unit spb_checker u_spb_checker (.*);

### verif/tb.sv
module tb;
  import spb_pkg::*;

  typedef struct packed {
    bar_t                 bar;
    ht_t                  height;
    ht_t                  peak;
    logic                 done;
    logic [ROW_W-1:0]     row;
    logic [CNT_W-1:0]     found;
    logic [FRM_W-1:0]     frame;
  } bar_update_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [6:0] channel, [7] strong_signal, [8] carrier_seen, zero above.
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [5:0] bar_index, [11:6] bar_height, [17:12] peak_height,
  // [81:18] waterfall_row, [88:82] signals_found, [120:89] frame_count.
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = REG_SCAN_ENABLE;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  ht_t              bar_level [NUM_BARS] = '{default: '0};
  ht_t              peak_level [NUM_BARS] = '{default: '0};
  logic [ROW_W-1:0] occupied = '0;
  logic [CNT_W-1:0] sweep_hits = '0;
  logic [FRM_W-1:0] sweeps_done = '0;
  logic             scan_on = 1'b0;
  ht_t              full_height = MAX_HEIGHT_RST;

  bar_update_t pending_updates[$];
  int          mismatches = 0;
  int          meas_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  always #5 clk = ~clk;

  spectrum_bar_peak_hold_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic bit update_bar(input logic [CH_W-1:0] ch, input logic strong_sig,
                                    input logic carrier, output bar_update_t u);
    int  b;
    ht_t goal;
    ht_t h;
    ht_t p;
    u = '0;
    if (!scan_on || ch > TOP_CH) return 1'b0;
    b = (int'(ch) * (NUM_BARS - 1)) / (NUM_CHANNELS - 1);
    if (strong_sig) goal = full_height;
    else if (carrier) goal = full_height >> 1;
    else goal = '0;
    if (goal != '0 && sweep_hits != CNT_MAX) sweep_hits++;
    h = bar_level[b];
    if (goal > h) h = goal;
    else if (h != '0) h--;
    bar_level[b] = h;
    p = peak_level[b];
    if (h > p) p = h;
    else if (p != '0) p--;
    peak_level[b] = p;
    occupied[b] = (h != '0);
    u.bar = bar_t'(b);
    u.height = h;
    u.peak = p;
    if (ch == TOP_CH) begin
      sweeps_done++;
      u.done = 1'b1;
      u.row = occupied;
      u.found = sweep_hits;
      u.frame = sweeps_done;
      sweep_hits = '0;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    bar_update_t u;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_addr == REG_SCAN_ENABLE) scan_on = cfg_wdata[0];
        else full_height = cfg_wdata;
      end
      if (in_tvalid && in_tready &&
          update_bar(in_tdata[6:0], in_tdata[7], in_tdata[8], u)) begin
        pending_updates.push_back(u);
        meas_count++;
      end
    end
  end

  always @(posedge clk) begin
    bar_update_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_updates.pop_front();
        check_field("bar_index", 64'(want.bar), 64'(out_tdata[5:0]));
        check_field("bar_height", 64'(want.height), 64'(out_tdata[11:6]));
        check_field("peak_height", 64'(want.peak), 64'(out_tdata[17:12]));
        check_field("waterfall_row", want.row, out_tdata[81:18]);
        check_field("signals_found", 64'(want.found), 64'(out_tdata[88:82]));
        check_field("frame_count", 64'(want.frame), 64'(out_tdata[120:89]));
        check_field("padding", '0, 64'(out_tdata[127:121]));
        check_field("sweep_done", 64'(want.done), 64'(out_tlast));
      end
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_meas(input logic [CH_W-1:0] ch, input logic strong_sig,
                           input logic carrier);
    int gap;
    in_tdata <= IN_TDATA_W'({carrier, strong_sig, ch});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The task stops driving, waits until the last expected beat has arrived
  // and then lets the clock run on idle before it returns.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_disabled_after_reset();
    send_meas(0, 1, 1);
    send_meas(TOP_CH, 1, 0);
    send_meas(50, 0, 1);
    wait_idle();
    write_reg(REG_SCAN_ENABLE, 1);
  endtask

  task automatic test_directed();
    send_meas(0, 1, 0);
    send_meas(1, 0, 0);
    send_meas(2, 0, 1);
    send_meas(62, 0, 1);
    send_meas(63, 1, 1);
    send_meas(127, 1, 1);
    send_meas(125, 0, 0);
    send_meas(126, 1, 0);
    send_meas(TOP_CH, 0, 0);
    wait_idle();
    write_reg(REG_MAX_HEIGHT, 63);
    send_meas(64, 0, 1);
    send_meas(TOP_CH, 1, 0);
    wait_idle();
    write_reg(REG_MAX_HEIGHT, 0);
    send_meas(10, 1, 0);
    send_meas(11, 0, 1);
    wait_idle();
    write_reg(REG_MAX_HEIGHT, 1);
    send_meas(12, 0, 1);
    send_meas(13, 1, 0);
    send_meas(TOP_CH, 0, 1);
    wait_idle();
    write_reg(REG_MAX_HEIGHT, 2);
    send_meas(5, 0, 1);
    send_meas(TOP_CH, 1, 1);
    wait_idle();
  endtask

  // Repeated channels drive more hits than the sweep's 7-bit signal count holds, so it saturates.
  task automatic test_count_saturation();
    write_reg(REG_MAX_HEIGHT, 40);
    for (int i = 0; i < 140; i++) send_meas(CH_W'(i % 124), 1, 1'($urandom_range(1)));
    send_meas(TOP_CH, 1, 0);
    wait_idle();
  endtask

  task automatic test_scan_pause();
    idle_pct = 25;
    stall_pct = 25;
    write_reg(REG_SCAN_ENABLE, 0);
    repeat (20) send_meas(CH_W'($urandom_range(127)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
    wait_idle();
    write_reg(REG_SCAN_ENABLE, 1);
  endtask

  task automatic test_sweeps(input int idle, input int stall, input int quota,
                             input int height);
    int stop;
    int s_pct;
    int c_pct;
    int first;
    int n;
    idle_pct = idle;
    stall_pct = stall;
    write_reg(REG_MAX_HEIGHT, height);
    stop = meas_count + quota;
    while (meas_count < stop) begin
      if ($urandom_range(99) < 75) begin
        s_pct = $urandom_range(40);
        c_pct = $urandom_range(60);
        first = ($urandom_range(3) == 0) ? $urandom_range(124) : 0;
        for (int ch = first; ch <= NUM_CHANNELS - 1; ch++)
          send_meas(CH_W'(ch), $urandom_range(99) < s_pct, $urandom_range(99) < c_pct);
      end else begin
        n = $urandom_range(5, 30);
        repeat (n) send_meas(CH_W'($urandom_range(127)), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
      end
      if ($urandom_range(9) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_after_reset();
    test_directed();
    test_count_saturation();
    test_sweeps(0, 0, 210, 63);
    test_sweeps(59, 0, 210, $urandom_range(2, 62));
    test_scan_pause();
    test_sweeps(0, 59, 210, 2);
    test_sweeps(25, 25, 210, $urandom_range(63));
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS spectrum_bar_peak_hold_unit");
    end else begin
      $display("FAIL spectrum_bar_peak_hold_unit");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL spectrum_bar_peak_hold_unit");
    $finish;
  end

endmodule
